FILE: rtl/hd44780_four_bit_sequencer_top_macros.svh
// assertion macros shared by the display sequencer
`ifndef HD44780_FOUR_BIT_SEQUENCER_TOP_MACROS_SVH
`define HD44780_FOUR_BIT_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define HDSEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HDSEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HDSEQ_ASSERT_IMP(lbl, ante, cons, msg)
`define HDSEQ_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/hdseq_pkg.sv
`default_nettype none

package hdseq_pkg;

  // operation codes on the request channel
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_INIT   = 3'd5;

  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;

  localparam logic [19:0] TICKS_PER_MS_RESET = 20'd16000;

  // step program: power-on sequence, clear starts part way in
  localparam logic [3:0] PROG_LEN   = 4'd12;
  localparam logic [3:0] PROG_CLEAR = 4'd10;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_BYTE,
    KIND_CLEAR,
    KIND_INIT,
    KIND_NONE
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] byte_val;
    logic       rs;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_EN_HIGH = 4'b0010,
    PH_EN_LOW  = 4'b0100,
    PH_WAIT    = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_NIB,
    ST_BYTE
  } step_kind_t;

  function automatic step_kind_t prog_kind(input logic [3:0] step);
    step_kind_t k;
    case (step)
      4'd0, 4'd2, 4'd4, 4'd11: k = ST_WAIT;
      4'd1, 4'd3, 4'd5, 4'd6:  k = ST_NIB;
      default:                 k = ST_BYTE;
    endcase
    return k;
  endfunction

  // power-on wait of step 0 comes from a parameter and is not in here
  function automatic logic [7:0] prog_val(input logic [3:0] step);
    logic [7:0] v;
    case (step)
      4'd1, 4'd3, 4'd5: v = 8'h30;
      4'd2:             v = 8'd5;
      4'd4:             v = 8'd1;
      4'd6:             v = 8'h20;
      4'd7:             v = 8'h28;
      4'd8:             v = 8'h0C;
      4'd9:             v = 8'h06;
      4'd10:            v = 8'h01;
      4'd11:            v = 8'd2;
      default:          v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hdseq_ifs.sv
`default_nettype none

interface hdseq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] byte_value;
  logic       row;
  logic [5:0] col;
  modport source (output valid, operation, byte_value, row, col, input ready);
  modport sink (input valid, operation, byte_value, row, col, output ready);
endinterface

interface hdseq_res_if;
  logic       valid;
  logic       ready;
  logic       rs_line;
  logic       enable_line;
  logic [3:0] data_nibble;
  logic       busy_res;
  logic       accepted;
  modport source (output valid, rs_line, enable_line, data_nibble, busy_res, accepted,
                  input ready);
  modport sink (input valid, rs_line, enable_line, data_nibble, busy_res, accepted,
                output ready);
endinterface

interface hdseq_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] ticks_per_ms;
  modport source (output valid, ticks_per_ms, input ready);
  modport sink (input valid, ticks_per_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/hd44780_four_bit_sequencer_top.sv
// channel | role   | payload
// req     | sink   | operation, byte_value, row, col
// res     | source | rs_line, enable_line, data_nibble, busy_res, accepted
// cfg     | sink   | ticks_per_ms (write only, always ready)
//
// one beat in and one beat out per cycle, sustained while res.ready is high;
// an item taken is written into the queue, executed from it by the back
// stage and then held in the result register until its result beat is taken
// execute settles one item per cycle when not stalled: counter step and compare
// rst is synchronous; ticks_per_ms returns to 16000, the display goes idle
// a stalled result holds the execute stage; the queue keeps taking items
// until QUEUE_DEPTH are waiting, then req.ready drops
`default_nettype none

module hd44780_four_bit_sequencer_top #(
  parameter int unsigned POWER_ON_MS = 50,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input wire logic     clk,
  input wire logic     rst,
  hdseq_req_if.sink    req,
  hdseq_res_if.source  res,
  hdseq_cfg_if.sink    cfg
);

  `include "hd44780_four_bit_sequencer_top_macros.svh"

  // timing base register, used from the next executed tick on
  logic [19:0] ticks_per_ms;

  hdseq_pkg::queue_status_t q_status;
  hdseq_pkg::item_t         push_item;
  hdseq_pkg::item_t         pop_item;
  logic                     push;
  logic                     pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= hdseq_pkg::TICKS_PER_MS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      ticks_per_ms <= cfg.ticks_per_ms;
    end
  end

  // front: take requests and decode them, cursor address worked out here
  hdseq_front u_front (
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // short queue between decode and execute
  hdseq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // back: pin latches, millisecond timing and the init/clear step program
  hdseq_back #(
    .POWER_ON_MS (POWER_ON_MS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ticks_per_ms (ticks_per_ms),
    .item         (pop_item),
    .q_status     (q_status),
    .pop          (pop),
    .res          (res)
  );

  // a taken request always leaves something in progress
  `HDSEQ_ASSERT_IMP(a_accept_busy, res.valid && res.accepted, res.busy_res, "accepted but idle")
  // strobe high only inside a transfer
  `HDSEQ_ASSERT_IMP(a_enable_busy, res.valid && res.enable_line, res.busy_res, "enable while idle")
  // queue flags never both set
  `HDSEQ_ASSERT_IMP(a_queue_flags, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
  // nothing is popped from an empty queue
  `HDSEQ_ASSERT_IMP(a_pop_empty, pop, !q_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/hdseq_front.sv
`default_nettype none

module hdseq_front (
  hdseq_req_if.sink                     req,
  input  wire hdseq_pkg::queue_status_t q_status,
  output logic                          push,
  output hdseq_pkg::item_t              push_item
);

  assign req.ready = !q_status.full;
  assign push      = req.valid && req.ready;

  always_comb begin
    push_item.byte_val = req.byte_value;
    push_item.rs       = 1'b0;
    case (req.operation)
      hdseq_pkg::OP_TICK: begin
        push_item.kind = hdseq_pkg::KIND_TICK;
      end
      hdseq_pkg::OP_CMD: begin
        push_item.kind = hdseq_pkg::KIND_BYTE;
      end
      hdseq_pkg::OP_DATA: begin
        push_item.kind = hdseq_pkg::KIND_BYTE;
        push_item.rs   = 1'b1;
      end
      hdseq_pkg::OP_CURSOR: begin
        // line base plus column, tops out at 0xff
        push_item.kind     = hdseq_pkg::KIND_BYTE;
        push_item.byte_val = (req.row ? hdseq_pkg::LINE1_BASE : hdseq_pkg::LINE0_BASE)
                             + {2'b00, req.col};
      end
      hdseq_pkg::OP_CLEAR: begin
        push_item.kind = hdseq_pkg::KIND_CLEAR;
      end
      hdseq_pkg::OP_INIT: begin
        push_item.kind = hdseq_pkg::KIND_INIT;
      end
      default: begin
        push_item.kind = hdseq_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hdseq_fifo.sv
`default_nettype none

module hdseq_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire hdseq_pkg::item_t     push_item,
  input  wire logic                 pop,
  output hdseq_pkg::item_t          pop_item,
  output hdseq_pkg::queue_status_t  status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  hdseq_pkg::item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == FULL_COUNT);
  assign status.empty = (count == '0);
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hdseq_back.sv
`default_nettype none

module hdseq_back #(
  parameter int unsigned POWER_ON_MS = 50
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [19:0]              ticks_per_ms,
  input  wire hdseq_pkg::item_t         item,
  input  wire hdseq_pkg::queue_status_t q_status,
  output logic                          pop,
  hdseq_res_if.source                   res
);

  localparam logic [7:0] POWER_ON_VAL = 8'(POWER_ON_MS);

  hdseq_pkg::phase_t phase, phase_next;
  logic [19:0] tick_count, tick_count_next;
  logic [5:0]  ms_left, ms_left_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        low_nibble_next, low_nibble_next_next;
  logic        rs_latch, rs_latch_next;
  logic        enable_latch, enable_latch_next;
  logic [3:0]  nibble_latch, nibble_latch_next;
  logic [3:0]  init_step, init_step_next;
  logic        acc;

  logic        do_step;
  logic [3:0]  step_k;
  logic [7:0]  step_val;
  logic [19:0] limit;
  logic [19:0] tick_inc;
  logic        is_idle;

  logic        out_valid;

  assign is_idle  = (phase == hdseq_pkg::PH_IDLE);
  assign limit    = (ticks_per_ms == '0) ? 20'd1 : ticks_per_ms;
  assign tick_inc = tick_count + 20'd1;
  assign step_val = (step_k == '0) ? POWER_ON_VAL : hdseq_pkg::prog_val(step_k);

  // output register frees up when empty or being taken
  assign pop = !q_status.empty && (!out_valid || res.ready);

  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    ms_left_next         = ms_left;
    held_byte_next       = held_byte;
    low_nibble_next_next = low_nibble_next;
    rs_latch_next        = rs_latch;
    enable_latch_next    = enable_latch;
    nibble_latch_next    = nibble_latch;
    init_step_next       = init_step;
    acc                  = 1'b0;
    do_step              = 1'b0;
    step_k               = init_step;

    case (item.kind)
      hdseq_pkg::KIND_TICK: begin
        if (!is_idle) begin
          if (tick_inc < limit) begin
            tick_count_next = tick_inc;
          end else begin
            tick_count_next = '0;
            if (ms_left > 6'd1) begin
              ms_left_next = ms_left - 6'd1;
            end else if (phase == hdseq_pkg::PH_EN_HIGH) begin
              enable_latch_next = 1'b0;
              phase_next        = hdseq_pkg::PH_EN_LOW;
              ms_left_next      = 6'd2;
            end else if (phase == hdseq_pkg::PH_EN_LOW && low_nibble_next) begin
              // second half of the byte
              low_nibble_next_next = 1'b0;
              nibble_latch_next    = held_byte[3:0];
              enable_latch_next    = 1'b1;
              phase_next           = hdseq_pkg::PH_EN_HIGH;
              ms_left_next         = 6'd1;
            end else begin
              do_step = 1'b1;
            end
          end
        end
      end
      hdseq_pkg::KIND_BYTE: begin
        if (is_idle) begin
          acc                  = 1'b1;
          init_step_next       = hdseq_pkg::PROG_LEN;
          held_byte_next       = item.byte_val;
          rs_latch_next        = item.rs;
          low_nibble_next_next = 1'b1;
          nibble_latch_next    = item.byte_val[7:4];
          enable_latch_next    = 1'b1;
          phase_next           = hdseq_pkg::PH_EN_HIGH;
          ms_left_next         = 6'd1;
          tick_count_next      = '0;
        end
      end
      hdseq_pkg::KIND_CLEAR: begin
        if (is_idle) begin
          acc     = 1'b1;
          step_k  = hdseq_pkg::PROG_CLEAR;
          do_step = 1'b1;
        end
      end
      hdseq_pkg::KIND_INIT: begin
        if (is_idle) begin
          acc           = 1'b1;
          step_k        = '0;
          rs_latch_next = 1'b0;
          do_step       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // advance the step program
    if (do_step) begin
      tick_count_next = '0;
      if (step_k >= hdseq_pkg::PROG_LEN) begin
        init_step_next    = step_k;
        phase_next        = hdseq_pkg::PH_IDLE;
        enable_latch_next = 1'b0;
        ms_left_next      = '0;
      end else begin
        init_step_next = step_k + 4'd1;
        case (hdseq_pkg::prog_kind(step_k))
          hdseq_pkg::ST_WAIT: begin
            enable_latch_next = 1'b0;
            phase_next        = hdseq_pkg::PH_WAIT;
            ms_left_next      = step_val[5:0];
          end
          hdseq_pkg::ST_NIB: begin
            rs_latch_next        = 1'b0;
            low_nibble_next_next = 1'b0;
            nibble_latch_next    = step_val[7:4];
            enable_latch_next    = 1'b1;
            phase_next           = hdseq_pkg::PH_EN_HIGH;
            ms_left_next         = 6'd1;
          end
          default: begin
            held_byte_next       = step_val;
            rs_latch_next        = 1'b0;
            low_nibble_next_next = 1'b1;
            nibble_latch_next    = step_val[7:4];
            enable_latch_next    = 1'b1;
            phase_next           = hdseq_pkg::PH_EN_HIGH;
            ms_left_next         = 6'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hdseq_pkg::PH_IDLE;
      tick_count      <= '0;
      ms_left         <= '0;
      held_byte       <= '0;
      low_nibble_next <= 1'b0;
      rs_latch        <= 1'b0;
      enable_latch    <= 1'b0;
      nibble_latch    <= '0;
      init_step       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        tick_count      <= tick_count_next;
        ms_left         <= ms_left_next;
        held_byte       <= held_byte_next;
        low_nibble_next <= low_nibble_next_next;
        rs_latch        <= rs_latch_next;
        enable_latch    <= enable_latch_next;
        nibble_latch    <= nibble_latch_next;
        init_step       <= init_step_next;
        out_valid       <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.rs_line     <= rs_latch_next;
      res.enable_line <= enable_latch_next;
      res.data_nibble <= nibble_latch_next;
      res.busy_res    <= (phase_next != hdseq_pkg::PH_IDLE);
      res.accepted    <= acc;
    end
  end

  assign res.valid = out_valid;

endmodule

`default_nettype wire
